FILE: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [2:0]  FULL_BYTES = 3'd4;
    localparam logic [3:0]  LEN_HI_POS = 4'd14;
    localparam logic [3:0]  LEN_LO_POS = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [5:0]  LAST_LOAD  = 6'd15;
    localparam logic [2:0]  LAST_INDEX = 3'd7;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        FR_DATA,
        FR_PAD,
        FR_TAIL,
        FR_FILL
    } t_front_state;

    typedef enum logic [1:0] {
        BK_ROUND,
        BK_FINAL,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic [31:0] word;
        logic        fin;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qwr;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qrd;

    function automatic logic [31:0] pad_word(input logic [31:0] word,
                                             input logic [1:0]  cnt);
        logic [31:0] keep;
        keep = ~(32'hffff_ffff >> {cnt, 3'b000});
        return (word & keep) | (PAD_WORD >> {cnt, 3'b000});
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

FILE: hdl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts message words, tracks length and block position, and appends the
// pad byte, zero words and bit length on the end of a message.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [31:0]        i_message_word,
    input  logic [2:0]         i_byte_count,
    input  logic               i_end_of_message,
    input  logic               i_q_full,
    output sha_pkg::t_qwr      o_qwr
);

    sha_pkg::t_front_state r_state, n_state;
    logic [3:0]            r_pos, n_pos;
    logic [63:0]           r_bits, n_bits;
    logic [2:0]            cnt;
    logic                  accept;

    assign o_full = (r_state != sha_pkg::FR_DATA) || i_q_full;
    assign accept = i_push && !o_full;
    assign cnt    = (i_byte_count > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
                                                         : i_byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::FR_DATA;
            r_pos   <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bits  <= n_bits;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_bits        = r_bits;
        o_qwr.valid   = 1'b0;
        o_qwr.ent     = '0;
        case (r_state)
            sha_pkg::FR_DATA: begin
                if (accept) begin
                    o_qwr.valid = 1'b1;
                    n_pos       = r_pos + 4'd1;
                    if (!i_end_of_message) begin
                        o_qwr.ent.word = i_message_word;
                        n_bits         = r_bits + 64'd32;
                    end else begin
                        n_bits = r_bits + {58'd0, cnt, 3'b000};
                        if (cnt == sha_pkg::FULL_BYTES) begin
                            o_qwr.ent.word = i_message_word;
                            n_state        = sha_pkg::FR_PAD;
                        end else begin
                            o_qwr.ent.word = sha_pkg::pad_word(i_message_word, cnt[1:0]);
                            n_state        = (r_pos == sha_pkg::LEN_HI_POS) ?
                                             sha_pkg::FR_TAIL : sha_pkg::FR_FILL;
                        end
                    end
                end
            end
            sha_pkg::FR_PAD: begin
                if (!i_q_full) begin
                    o_qwr.valid    = 1'b1;
                    o_qwr.ent.word = sha_pkg::PAD_WORD;
                    n_pos          = r_pos + 4'd1;
                    n_state        = (r_pos == sha_pkg::LEN_HI_POS) ?
                                     sha_pkg::FR_TAIL : sha_pkg::FR_FILL;
                end
            end
            sha_pkg::FR_TAIL: begin
                // no room for the length here: close this block with a zero
                if (!i_q_full) begin
                    o_qwr.valid = 1'b1;
                    n_pos       = r_pos + 4'd1;
                    n_state     = sha_pkg::FR_FILL;
                end
            end
            sha_pkg::FR_FILL: begin
                if (!i_q_full) begin
                    o_qwr.valid = 1'b1;
                    n_pos       = r_pos + 4'd1;
                    if (r_pos == sha_pkg::LEN_HI_POS) begin
                        o_qwr.ent.word = r_bits[63:32];
                    end else if (r_pos == sha_pkg::LEN_LO_POS) begin
                        o_qwr.ent.word = r_bits[31:0];
                        o_qwr.ent.fin  = 1'b1;
                        n_bits         = '0;
                        n_state        = sha_pkg::FR_DATA;
                    end
                end
            end
            default: begin
                n_state = sha_pkg::FR_DATA;
            end
        endcase
    end

endmodule

FILE: hdl/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo
// Short word queue between the front and the compression back end.
// ----------------------------------------------------------------------------
module sha_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_qwr i_qwr,
    output logic          o_full,
    input  logic          i_pop,
    output sha_pkg::t_qrd o_qrd
);

    sha_pkg::t_qent                 r_mem [sha_pkg::QDEPTH];
    logic [sha_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [sha_pkg::QCNT_W-1:0]     r_cnt;
    logic                           wr, rd;

    assign o_full      = (r_cnt == sha_pkg::QCNT_W'(sha_pkg::QDEPTH));
    assign o_qrd.valid = (r_cnt != '0);
    assign o_qrd.ent   = r_mem[r_rd];
    assign wr          = i_qwr.valid && !o_full;
    assign rd          = i_pop && o_qrd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= r_wr + sha_pkg::QPTR_W'(1);
            end
            if (rd) begin
                r_rd <= r_rd + sha_pkg::QPTR_W'(1);
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + sha_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - sha_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_qwr.ent;
        end
    end

endmodule

FILE: hdl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Runs one SHA-256 round per cycle unless stalled on an empty queue, folds the
// block into the hash state and presents the digest one word per transfer.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_qrd i_qrd,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);

    sha_pkg::t_back_state r_state, n_state;
    logic [5:0]           r_t, n_t;
    logic [2:0]           r_idx, n_idx;
    logic                 r_fin, n_fin;
    logic [31:0]          r_v [8];
    logic [31:0]          n_v [8];
    logic [31:0]          r_h [8];
    logic [31:0]          n_h [8];
    logic [31:0]          r_win [16];
    logic [31:0]          n_win [16];
    logic [31:0]          sched, wt, t1, t2, ch, mj;
    logic                 load_phase, advance;

    assign load_phase = (r_t <= sha_pkg::LAST_LOAD);
    assign sched = sha_pkg::ssig1(r_win[14]) + r_win[9] + sha_pkg::ssig0(r_win[1]) + r_win[0];
    assign wt    = load_phase ? i_qrd.ent.word : sched;
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + sha_pkg::bsig1(r_v[4]) + ch + sha_pkg::ROUND_K[r_t] + wt;
    assign t2    = sha_pkg::bsig0(r_v[0]) + mj;

    assign o_q_pop       = (r_state == sha_pkg::BK_ROUND) && load_phase && i_qrd.valid;
    assign advance       = (r_state == sha_pkg::BK_ROUND) && (!load_phase || i_qrd.valid);
    assign o_empty       = (r_state != sha_pkg::BK_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == sha_pkg::LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::BK_ROUND;
            r_t     <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_v     <= sha_pkg::INIT_H;
            r_h     <= sha_pkg::INIT_H;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
            r_v     <= n_v;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_idx   = r_idx;
        n_fin   = r_fin;
        n_v     = r_v;
        n_h     = r_h;
        n_win   = r_win;
        case (r_state)
            sha_pkg::BK_ROUND: begin
                if (advance) begin
                    for (int i = 0; i < 15; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[15] = wt;
                    n_v[7] = r_v[6];
                    n_v[6] = r_v[5];
                    n_v[5] = r_v[4];
                    n_v[4] = r_v[3] + t1;
                    n_v[3] = r_v[2];
                    n_v[2] = r_v[1];
                    n_v[1] = r_v[0];
                    n_v[0] = t1 + t2;
                    n_t    = r_t + 6'd1;
                    if (r_t == sha_pkg::LAST_LOAD) begin
                        n_fin = i_qrd.ent.fin;
                    end
                    if (r_t == sha_pkg::LAST_ROUND) begin
                        n_state = sha_pkg::BK_FINAL;
                    end
                end
            end
            sha_pkg::BK_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                    n_v[i] = r_h[i] + r_v[i];
                end
                n_idx   = '0;
                n_state = r_fin ? sha_pkg::BK_OUT : sha_pkg::BK_ROUND;
            end
            sha_pkg::BK_OUT: begin
                if (i_pop) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha_pkg::LAST_INDEX) begin
                        n_h     = sha_pkg::INIT_H;
                        n_v     = sha_pkg::INIT_H;
                        n_fin   = 1'b0;
                        n_state = sha_pkg::BK_ROUND;
                    end
                end
            end
            default: begin
                n_state = sha_pkg::BK_ROUND;
            end
        endcase
    end

endmodule

FILE: hdl/sha256_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// SHA-256 engine: a front end that takes words and pads messages, a short
// queue, and a back end that compresses blocks and returns the digest.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  input     push / full    i_message_word, i_byte_count, i_end_of_message
//  result    empty / pop    o_digest_word, o_word_index, o_last_word
//
//  One round per cycle: a block of 16 words goes through 64 rounds and one
//  add into the hash.
//  Rounds 0 to 15 consume queued words; the back end stalls on an empty queue.
//  full stays high while the 2 to 18 padding and length words are generated.
//  The digest waits in the hash registers; the next block starts after pop
//  of word 7. Reset is synchronous and loads the initial hash values.
// ----------------------------------------------------------------------------
module sha256_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha_pkg::t_qwr qwr;
    sha_pkg::t_qrd qrd;
    logic          q_full;
    logic          q_pop;

    sha_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_message_word   (i_message_word),
        .i_byte_count     (i_byte_count),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (q_full),
        .o_qwr            (qwr)
    );

    sha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_qrd   (qrd)
    );

    sha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qrd         (qrd),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

FILE: hdl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks on the digest channel of the SHA-256 engine.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result channel not empty after reset");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("stalled digest word changed");

    a_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == sha_pkg::LAST_INDEX)))
        else $error("last_word does not match word_index");

    a_next_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=>
            (!empty && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not in sequence");

    a_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty)
        else $error("result shown right after the final digest word");

endmodule

bind sha256_hash_engine_core sha_checker u_sha_checker (.*);
